// ===== rtl/assert_macros.svh =====
// Assertion macros included by the transposition table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of i_clk outside reset.
`define BTT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge of i_clk outside reset.
`define BTT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/btt_pkg.sv =====
// Types and constants of the bucketed transposition table.
package btt_pkg;

    localparam int TAG_W   = 32;
    localparam int SCORE_W = 16;
    localparam int MOVE_W  = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int AGE_W   = 6;

    // Width of the signed replacement score: depth difference plus small bonuses.
    localparam int PTS_W = DEPTH_W + 2;

    localparam logic       OP_PROBE = 1'b0;
    localparam logic       OP_STORE = 1'b1;
    localparam logic [1:0] BOUND_EXACT  = 2'd0;
    localparam logic [1:0] BOUND_LOWER  = 2'd1;
    localparam logic [1:0] BOUND_UPPER  = 2'd2;
    // Code 3 is kept as given and counts as non-exact.
    localparam logic [1:0] BOUND_UNUSED = 2'd3;

    localparam logic signed [PTS_W-1:0] STALE_PTS = PTS_W'(4);

    // One way of a bucket.
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]  move;
        logic [DEPTH_W-1:0] depth;
        logic [BOUND_W-1:0] bound;
        logic [AGE_W-1:0]   age;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

endpackage

// ===== rtl/btt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module btt_ram #(
    parameter int WIDTH = 320,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// ===== rtl/bucketed_transposition_table.sv =====
// Bucketed transposition table: set-associative store of search results.
// o_done is registered: the taken start beat moves the state to lookup, and the result beat follows from there.
// A new probe or store is taken only in idle: busy holds off commands during the bucket read and write-back.
// Reset: synchronous and active low; afterwards a clearing pass writes every bucket
// row to zero in turn, with busy high. The receiver cannot stall.
module bucketed_transposition_table
    import btt_pkg::*;
#(
    parameter int NUM_BUCKETS = 1024,
    parameter int WAYS        = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Command channel
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_operation,
    input  logic [63:0]                i_key,
    input  logic signed [SCORE_W-1:0]  i_score,
    input  logic [DEPTH_W-1:0]         i_depth,
    input  logic [BOUND_W-1:0]         i_bound,
    input  logic [MOVE_W-1:0]          i_best_move,
    // Configuration channel: the current search generation
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [AGE_W-1:0]           i_cfg_data,
    // Result channel
    output logic                       o_done,
    output logic                       o_hit,
    output logic                       o_written,
    output logic [1:0]                 o_way,
    output logic signed [SCORE_W-1:0]  o_entry_score,
    output logic [MOVE_W-1:0]          o_entry_move,
    output logic [DEPTH_W-1:0]         o_entry_depth,
    output logic [BOUND_W-1:0]         o_entry_bound,
    output logic [AGE_W-1:0]           o_entry_age
);

    // Each memory row holds one whole bucket, so a single read brings in every way
    // and a single write puts the modified bucket back.
    localparam int IDX_W = $clog2(NUM_BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * SLOT_W;

    // The bucket index is the key masked with NUM_BUCKETS - 1, as for a power of two;
    // for other counts some rows are simply never addressed.
    localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(NUM_BUCKETS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_BUCKETS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    t_state r_state;

    // Clearing pass
    logic [IDX_W-1:0] r_clr_idx;

    // Configuration
    logic [AGE_W-1:0] r_current_age;

    // Command held for the lookup cycle
    logic               r_op;
    logic [IDX_W-1:0]   r_idx;
    logic [TAG_W-1:0]   r_tag;
    logic [SCORE_W-1:0] r_score;
    logic [DEPTH_W-1:0] r_depth;
    logic [BOUND_W-1:0] r_bound;
    logic [MOVE_W-1:0]  r_move;

    // Result registers
    logic               r_done;
    logic               r_hit;
    logic               r_written;
    logic [1:0]         r_way;
    logic [SCORE_W-1:0] r_entry_score;
    logic [MOVE_W-1:0]  r_entry_move;
    logic [DEPTH_W-1:0] r_entry_depth;
    logic [BOUND_W-1:0] r_entry_bound;
    logic [AGE_W-1:0]   r_entry_age;

    // Memory ports
    logic             accept;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [ROW_W-1:0] ram_rdata;

    // Lookup logic
    t_slot [WAYS-1:0] rd_row;
    t_slot [WAYS-1:0] wr_row;
    t_slot            new_slot;
    t_slot            hit_slot;
    logic             p_hit;
    logic [WAY_W-1:0] p_sel;
    logic             s_found;
    logic             s_have;
    logic             s_refresh;
    logic             s_write;
    logic [WAY_W-1:0] s_sel;
    logic signed [PTS_W-1:0] s_best;
    logic signed [PTS_W-1:0] s_pts;
    logic             new_exact;
    logic [WAY_W+1:0] way_ext;

    logic             n_hit;
    logic             n_written;
    logic [1:0]       n_way;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // The read is issued on the accepting edge, so the bucket is in ram_rdata during
    // the lookup cycle. Its write-back lands on the edge that ends the lookup cycle,
    // and busy keeps the next read off that same edge, so no forwarding is needed.
    assign ram_raddr = i_key[IDX_W-1:0] & IDX_MASK;
    assign ram_we    = (r_state == ST_CLEAR) || ((r_state == ST_LOOKUP) && (r_op == OP_STORE));
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_idx : r_idx;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : ROW_W'(wr_row);

    btt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_BUCKETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_row = ram_rdata;

    assign new_exact = (r_bound == BOUND_EXACT);

    always_comb begin
        new_slot.tag   = r_tag;
        new_slot.score = r_score;
        new_slot.move  = r_move;
        new_slot.depth = r_depth;
        new_slot.bound = r_bound;
        new_slot.age   = r_current_age;
    end

    // Probe: the first way whose tag equals the key's tag. An empty way carries a
    // zero tag, so a probe with a zero tag hits the first empty way.
    always_comb begin
        p_hit = 1'b0;
        p_sel = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!p_hit && (rd_row[w].tag == r_tag)) begin
                p_hit = 1'b1;
                p_sel = WAY_W'(w);
            end
        end
    end

    // Store: walk the ways in order. The first empty way is taken at once; a way
    // with the same tag gets its age refreshed and is overwritten unless the new
    // result is shallower or would put a non-exact bound over an exact one. Ways
    // passed over on the way compete on replacement score, the first winning ties.
    always_comb begin
        s_found   = 1'b0;
        s_have    = 1'b0;
        s_refresh = 1'b0;
        s_write   = 1'b0;
        s_sel     = '0;
        s_best    = '0;
        s_pts     = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (!s_found) begin
                if (rd_row[w].tag == '0) begin
                    s_found = 1'b1;
                    s_write = 1'b1;
                    s_sel   = WAY_W'(w);
                end else if (rd_row[w].tag == r_tag) begin
                    s_found   = 1'b1;
                    s_refresh = 1'b1;
                    s_sel     = WAY_W'(w);
                    s_write   = !((r_depth < rd_row[w].depth) ||
                                  ((rd_row[w].bound == BOUND_EXACT) && !new_exact));
                end else begin
                    s_pts = signed'(PTS_W'({2'b00, r_depth}))
                          - signed'(PTS_W'({2'b00, rd_row[w].depth}));
                    if (rd_row[w].age != r_current_age) begin
                        s_pts = s_pts + STALE_PTS;
                    end
                    if (rd_row[w].bound == BOUND_EXACT) begin
                        s_pts = s_pts - PTS_W'(1);
                    end
                    if (new_exact) begin
                        s_pts = s_pts + PTS_W'(1);
                    end
                    if (!s_have || (s_best < s_pts)) begin
                        s_have = 1'b1;
                        s_best = s_pts;
                        s_sel  = WAY_W'(w);
                    end
                end
            end
        end
        if (!s_found) begin
            s_write = 1'b1;
        end
    end

    always_comb begin
        wr_row = rd_row;
        if (s_refresh) begin
            wr_row[s_sel].age = r_current_age;
        end
        if (s_write) begin
            wr_row[s_sel] = new_slot;
        end
    end

    assign hit_slot = rd_row[p_sel];

    always_comb begin
        if (r_op == OP_PROBE) begin
            n_hit     = p_hit;
            n_written = 1'b0;
            way_ext   = {2'b00, (p_hit ? p_sel : WAY_W'(0))};
        end else begin
            n_hit     = 1'b0;
            n_written = s_write;
            way_ext   = {2'b00, s_sel};
        end
        n_way = way_ext[1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_idx     <= '0;
            r_current_age <= '0;
            r_done        <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_current_age <= i_cfg_data;
            end
            r_done <= 1'b0;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                    if (r_clr_idx == IDX_LAST) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= ST_LOOKUP;
                        r_op    <= i_operation;
                        r_idx   <= ram_raddr;
                        r_tag   <= i_key[63 -: TAG_W];
                        r_score <= $unsigned(i_score);
                        r_depth <= i_depth;
                        r_bound <= i_bound;
                        r_move  <= i_best_move;
                    end
                end
                ST_LOOKUP: begin
                    r_state   <= ST_IDLE;
                    r_done    <= 1'b1;
                    r_hit     <= n_hit;
                    r_written <= n_written;
                    r_way     <= n_way;
                    if (n_hit) begin
                        r_entry_score <= hit_slot.score;
                        r_entry_move  <= hit_slot.move;
                        r_entry_depth <= hit_slot.depth;
                        r_entry_bound <= hit_slot.bound;
                        r_entry_age   <= hit_slot.age;
                    end else begin
                        r_entry_score <= '0;
                        r_entry_move  <= '0;
                        r_entry_depth <= '0;
                        r_entry_bound <= '0;
                        r_entry_age   <= '0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_hit         = r_hit;
    assign o_written     = r_written;
    assign o_way         = r_way;
    assign o_entry_score = signed'(r_entry_score);
    assign o_entry_move  = r_entry_move;
    assign o_entry_depth = r_entry_depth;
    assign o_entry_bound = r_entry_bound;
    assign o_entry_age   = r_entry_age;

    `include "assert_macros.svh"

    // Every lookup cycle ends in exactly one result beat.
    `BTT_ASSERT_NXT(a_lookup_done, r_state == ST_LOOKUP, o_done, "lookup without result beat")
    // A taken command always moves into the lookup cycle with busy raised.
    `BTT_ASSERT_NXT(a_accept_busy, accept, busy && (r_state == ST_LOOKUP), "accept, no lookup")
    // A beat never reports both a probe hit and a store write.
    `BTT_ASSERT_IMP(a_hit_xor_write, o_done, !(o_hit && o_written), "hit and written together")
    // A hit only ever comes from a probe.
    `BTT_ASSERT_IMP(a_hit_probe, o_hit && o_done, r_op == OP_PROBE, "hit reported for a store")

endmodule
